// ===== rtl/core/prfcw_pkg.sv =====
// prfcw_pkg: types, constants and widths shared by the PLL rate calculator.
// No dependencies; imported by every module of the block.
package prfcw_pkg;

	localparam int OPC_W = 4;
	localparam int WORD_W = 32;
	localparam int RATE_W = 39;  // parent (32 b) times the largest factor (128)
	localparam int FAC_W = 8;    // multiplier factor, at most 128
	localparam int DIV_W = 10;   // divisor, at most 512 (audio P*M)
	localparam int REM_W = DIV_W - 1;  // remainder is below the divisor
	localparam int SHIFT_W = 2;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [WORD_W-1:0] FIXED_HI = 32'd297_000_000;
	localparam logic [WORD_W-1:0] FIXED_LO = 32'd270_000_000;

	localparam int BIT_INT_MODE = 24;
	localparam int BIT_SEL_HI = 25;

	typedef enum logic [OPC_W-1:0] {
		SEL_CPU     = 4'd0,
		SEL_AUDIO   = 4'd1,
		SEL_VIDEO   = 4'd2,
		SEL_VE      = 4'd3,
		SEL_DDR0    = 4'd4,
		SEL_PERIPH0 = 4'd5,
		SEL_ISP     = 4'd6,
		SEL_PERIPH1 = 4'd7,
		SEL_DDR1    = 4'd8
	} pll_sel_t;

	// Decoded job: rate = ((parent * fac) >> shift) / div
	typedef struct packed {
		logic [WORD_W-1:0]  parent;
		logic [FAC_W-1:0]   fac;
		logic [SHIFT_W-1:0] shift;
		logic [DIV_W-1:0]   div;
		logic               sel_ok;
	} job_t;

endpackage

// ===== rtl/core/prfcw_front.sv =====
// prfcw_front: input handshake and per-PLL decode of the control word
// into a multiply/shift/divide job. Depends on prfcw_pkg.
module prfcw_front import prfcw_pkg::*; (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OPC_W-1:0]  opcode,
	input  logic [WORD_W-1:0] ctrl_word,
	input  logic [WORD_W-1:0] parent_rate,
	input  logic              q_full,
	output logic              push,
	output job_t              job
);

	logic [5:0] n5;
	logic [2:0] k2;
	logic [8:0] nk;
	logic [2:0] m2;
	logic [4:0] m4;
	logic [7:0] n7;
	logic [4:0] n4;
	logic [5:0] am;
	logic [4:0] ap;
	logic [9:0] apm;

	assign in_ready = !q_full;
	assign push = in_valid && in_ready;

	assign n5 = {1'b0, ctrl_word[12:8]} + 6'd1;
	assign k2 = {1'b0, ctrl_word[5:4]} + 3'd1;
	assign nk = {3'd0, n5} * {6'd0, k2};
	assign m2 = {1'b0, ctrl_word[1:0]} + 3'd1;
	assign m4 = {1'b0, ctrl_word[3:0]} + 5'd1;
	assign n7 = {1'b0, ctrl_word[14:8]} + 8'd1;
	assign n4 = {1'b0, ctrl_word[11:8]} + 5'd1;
	assign am = {1'b0, ctrl_word[4:0]} + 6'd1;
	assign ap = {1'b0, ctrl_word[19:16]} + 5'd1;
	assign apm = {4'd0, am} * {5'd0, ap};

	always_comb begin
		job.parent = parent_rate;
		job.fac = FAC_W'(1);
		job.shift = '0;
		job.div = DIV_W'(1);
		job.sel_ok = 1'b1;
		case (opcode)
			SEL_CPU: begin
				job.fac = nk[FAC_W-1:0];
				job.shift = ctrl_word[17:16];
				job.div = DIV_W'(m2);
			end
			SEL_AUDIO: begin
				job.fac = ctrl_word[BIT_INT_MODE] ? FAC_W'(n4) : n7;
				job.div = apm;
			end
			SEL_VIDEO, SEL_VE, SEL_ISP: begin
				if (ctrl_word[BIT_INT_MODE]) begin
					job.fac = n7;
					job.div = (opcode == SEL_VIDEO) ? DIV_W'(m2) : DIV_W'(m4);
				end else begin
					job.parent = ctrl_word[BIT_SEL_HI] ? FIXED_HI : FIXED_LO;
				end
			end
			SEL_DDR0: begin
				job.fac = nk[FAC_W-1:0];
				job.div = DIV_W'(m2);
			end
			SEL_PERIPH0, SEL_PERIPH1: begin
				if (!ctrl_word[BIT_SEL_HI]) begin
					job.fac = nk[FAC_W-1:0];
					job.div = DIV_W'(2);
				end
			end
			SEL_DDR1: begin
				job.fac = n7;
				job.div = DIV_W'(m2);
			end
			default: begin
				// unknown selector: zero operand gives a zero rate
				job.parent = '0;
				job.sel_ok = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/prfcw_queue.sv =====
// prfcw_queue: small FIFO of decoded jobs between front and back.
// Depends on prfcw_pkg. DEPTH must be a power of two, at least 2.
module prfcw_queue import prfcw_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t               mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

endmodule

// ===== rtl/core/prfcw_back.sv =====
// prfcw_back: multiply, post-shift and a restoring divider with one
// quotient bit per stage. Depends on prfcw_pkg.
module prfcw_back import prfcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  job_t              job,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [RATE_W-1:0] out_rate,
	output logic              select_valid
);

	localparam int STAGES = RATE_W;

	logic                en;

	logic                v_s1;
	logic [RATE_W-1:0]   prod_s1;
	logic [SHIFT_W-1:0]  shift_s1;
	logic [DIV_W-1:0]    dv_s1;
	logic                ok_s1;

	// divide chain, sd index d: index 0 holds the shifted dividend (stage s2),
	// index d > 0 has d quotient bits resolved; index STAGES drives the outputs
	logic                v_sd   [STAGES+1];
	logic                ok_sd  [STAGES+1];
	logic [RATE_W-1:0]   dq_sd  [STAGES+1];
	logic [REM_W-1:0]    rem_sd [STAGES];
	logic [DIV_W-1:0]    dv_sd  [STAGES];

	logic [DIV_W-1:0]    trial_c [STAGES];
	logic [DIV_W-1:0]    diff_c  [STAGES];
	logic                ge_c    [STAGES];

	assign en = !v_sd[STAGES] || out_ready;
	assign job_ready = en;

	assign out_valid = v_sd[STAGES];
	assign out_rate = dq_sd[STAGES];
	assign select_valid = ok_sd[STAGES];

	always_comb begin
		for (int k = 0; k < STAGES; k++) begin
			trial_c[k] = {rem_sd[k], dq_sd[k][RATE_W-1]};
			ge_c[k] = (trial_c[k] >= dv_sd[k]);
			diff_c[k] = trial_c[k] - dv_sd[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k <= STAGES; k++)
				v_sd[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= job_valid;
			v_sd[0] <= v_s1;
			for (int k = 0; k < STAGES; k++)
				v_sd[k+1] <= v_sd[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= RATE_W'(job.parent) * RATE_W'(job.fac);
			shift_s1 <= job.shift;
			dv_s1 <= job.div;
			ok_s1 <= job.sel_ok;

			dq_sd[0] <= prod_s1 >> shift_s1;
			rem_sd[0] <= '0;
			dv_sd[0] <= dv_s1;
			ok_sd[0] <= ok_s1;

			for (int k = 0; k < STAGES; k++) begin
				dq_sd[k+1] <= {dq_sd[k][RATE_W-2:0], ge_c[k]};
				ok_sd[k+1] <= ok_sd[k];
			end
			for (int k = 0; k < STAGES - 1; k++) begin
				rem_sd[k+1] <= ge_c[k] ? diff_c[k][REM_W-1:0] : trial_c[k][REM_W-1:0];
				dv_sd[k+1] <= dv_sd[k];
			end
		end
	end

endmodule

// ===== rtl/core/pll_rate_from_control_word_top.sv =====
// Channel  | handshake           | payload
// in       | in_valid/in_ready   | opcode, ctrl_word, parent_rate
// out      | out_valid/out_ready | out_rate, select_valid
//
// One transaction per cycle sustained while the output is not stalled; the result
// passes through the job queue and the multiply and shift stages, then the 39-stage
// restoring divider. The pipeline advances as a whole when its last stage is free or
// being taken; during an output stall incoming transactions fill the QUEUE_DEPTH-entry
// job queue, then in_ready drops.
// arst_n clears the queue and all stage valids; no clearing pass is needed.
//
// Top level of the PLL rate calculator: front decode, job queue, back
// arithmetic. Depends on prfcw_pkg, prfcw_front, prfcw_queue, prfcw_back.
module pll_rate_from_control_word_top import prfcw_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OPC_W-1:0]  opcode,
	input  logic [WORD_W-1:0] ctrl_word,
	input  logic [WORD_W-1:0] parent_rate,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [RATE_W-1:0] out_rate,
	output logic              select_valid
);

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	logic back_ready;
	job_t new_job;
	job_t head_job;

	assign pop = back_ready && !q_empty;

	prfcw_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.ctrl_word   (ctrl_word),
		.parent_rate (parent_rate),
		.q_full      (q_full),
		.push        (push),
		.job         (new_job)
	);

	prfcw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (new_job),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head_job)
	);

	prfcw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (!q_empty),
		.job_ready    (back_ready),
		.job          (head_job),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_rate     (out_rate),
		.select_valid (select_valid)
	);

endmodule

// ===== rtl/core/prfcw_checker.sv =====
// prfcw_checker: port-level assertions for the PLL rate calculator, bound
// to pll_rate_from_control_word_top. Depends on prfcw_pkg.
module prfcw_checker import prfcw_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [RATE_W-1:0] out_rate,
	input logic              select_valid
);

	// transactions in flight; 8 bits covers queue plus pipeline depth
	logic [7:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_rate) && $stable(select_valid))
		else $error("result changed or dropped while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 8'd0)
		else $error("result without a matching input transaction");

	a_bad_sel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !select_valid |-> out_rate == '0)
		else $error("unknown selector gave a nonzero rate");

	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind pll_rate_from_control_word_top prfcw_checker u_prfcw_checker (.*);

// ===== tb/pll_rate_from_control_word_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for pll_rate_from_control_word_top: directed table, then random bursts, each
// output checked against a typed row's result or an in-bench rate calculation. Depends on prfcw_pkg.
module pll_rate_from_control_word_top_tb;
	import prfcw_pkg::*;

	localparam logic [OPC_W-1:0] SEL_FIRST_BAD = 4'd9;
	localparam logic [OPC_W-1:0] SEL_LAST_BAD = 4'd15;
	localparam logic [WORD_W-1:0] PAR_24M = 32'd24_000_000;
	localparam logic [WORD_W-1:0] PAR_MAX = 32'hFFFF_FFFF;
	localparam int N_RANDOM = 1650;
	localparam int N_DIRECTED = 22;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400_000;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              ok;
	} pll_result_t;

	typedef struct packed {
		logic [OPC_W-1:0]  opc;
		logic [WORD_W-1:0] word;
		logic [WORD_W-1:0] parent;
		logic              typed;
		logic [RATE_W-1:0] rate;
		logic              ok;
	} dir_row_t;

	// typed rows carry their own expected result; the rest use calc_pll_rate
	dir_row_t dir_rows [N_DIRECTED] = '{
		'{SEL_CPU,     32'h0000_0000, PAR_24M,       1'b0, 39'd0, 1'b0},
		'{SEL_CPU,     32'h0003_1F33, PAR_MAX,       1'b1, 39'h3_FFFF_FFFC, 1'b1},
		'{SEL_CPU,     32'hFFFF_FFFF, PAR_MAX,       1'b1, 39'h3_FFFF_FFFC, 1'b1},
		'{SEL_AUDIO,   32'h010F_0F1F, PAR_24M,       1'b0, 39'd0, 1'b0},
		'{SEL_AUDIO,   32'h000F_7F1F, PAR_MAX,       1'b0, 39'd0, 1'b0},
		'{SEL_AUDIO,   32'h0000_0000, 32'd0,         1'b1, 39'd0, 1'b1},
		'{SEL_VIDEO,   32'h0100_7F03, PAR_24M,       1'b0, 39'd0, 1'b0},
		'{SEL_VIDEO,   32'h0200_0000, PAR_24M,       1'b1, 39'd297_000_000, 1'b1},
		'{SEL_VIDEO,   32'h0000_FFFF, PAR_MAX,       1'b1, 39'd270_000_000, 1'b1},
		'{SEL_VE,      32'hFEFF_FFFF, PAR_MAX,       1'b1, 39'd297_000_000, 1'b1},
		'{SEL_VE,      32'h0100_7F0F, PAR_MAX,       1'b0, 39'd0, 1'b0},
		'{SEL_ISP,     32'hFFFF_FFFF, PAR_24M,       1'b0, 39'd0, 1'b0},
		'{SEL_ISP,     32'h0000_0000, PAR_MAX,       1'b1, 39'd270_000_000, 1'b1},
		'{SEL_DDR0,    32'h0000_1F30, PAR_MAX,       1'b1, 39'h7F_FFFF_FF80, 1'b1},
		'{SEL_DDR0,    32'h0000_0A12, PAR_24M,       1'b0, 39'd0, 1'b0},
		'{SEL_PERIPH0, 32'h0200_0000, 32'hDEAD_BEEF, 1'b1, 39'h00_DEAD_BEEF, 1'b1},
		'{SEL_PERIPH0, 32'h0000_1F30, PAR_MAX,       1'b1, 39'h3F_FFFF_FFC0, 1'b1},
		'{SEL_PERIPH1, 32'hFFFF_FFFF, PAR_MAX,       1'b1, 39'h00_FFFF_FFFF, 1'b1},
		'{SEL_PERIPH1, 32'h0000_0B10, 32'd12_345_679, 1'b0, 39'd0, 1'b0},
		'{SEL_DDR1,    32'h0000_7F00, PAR_MAX,       1'b1, 39'h7F_FFFF_FF80, 1'b1},
		'{SEL_FIRST_BAD, 32'hFFFF_FFFF, PAR_MAX,     1'b1, 39'd0, 1'b0},
		'{SEL_LAST_BAD,  32'h0000_0000, PAR_24M,     1'b1, 39'd0, 1'b0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [OPC_W-1:0]  opcode = '0;
	logic [WORD_W-1:0] ctrl_word = '0;
	logic [WORD_W-1:0] parent_rate = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [RATE_W-1:0] out_rate;
	logic              select_valid;

	// typed expectation riding along with the payload of the current transaction
	logic              row_typed = 1'b0;
	pll_result_t       row_result = '0;

	pll_result_t       rate_q[$];
	int                err_cnt = 0;
	int                cycle_cnt = 0;
	int                stall_cnt = 0;
	int                stall_mode = 0;

	pll_rate_from_control_word_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.ctrl_word    (ctrl_word),
		.parent_rate  (parent_rate),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_rate     (out_rate),
		.select_valid (select_valid)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic pll_result_t calc_pll_rate(logic [OPC_W-1:0] opc,
			logic [WORD_W-1:0] w, logic [WORD_W-1:0] par);
		logic [63:0] p64, n, k, m, p, rate;
		pll_result_t r;
		p64 = {32'd0, par};
		rate = '0;
		r.ok = 1'b1;
		case (opc)
		SEL_CPU: begin
			n = w[12:8] + 64'd1;
			k = w[5:4] + 64'd1;
			m = w[1:0] + 64'd1;
			rate = ((p64 * n * k) >> w[17:16]) / m;
		end
		SEL_AUDIO: begin
			n = w[BIT_INT_MODE] ? w[11:8] + 64'd1 : w[14:8] + 64'd1;
			m = w[4:0] + 64'd1;
			p = w[19:16] + 64'd1;
			rate = (p64 * n) / (p * m);
		end
		SEL_VIDEO, SEL_VE, SEL_ISP: begin
			if (w[BIT_INT_MODE]) begin
				n = w[14:8] + 64'd1;
				m = (opc == SEL_VIDEO) ? w[1:0] + 64'd1 : w[3:0] + 64'd1;
				rate = (p64 * n) / m;
			end else begin
				rate = w[BIT_SEL_HI] ? 64'(FIXED_HI) : 64'(FIXED_LO);
			end
		end
		SEL_DDR0: begin
			n = w[12:8] + 64'd1;
			k = w[5:4] + 64'd1;
			m = w[1:0] + 64'd1;
			rate = (p64 * n * k) / m;
		end
		SEL_PERIPH0, SEL_PERIPH1: begin
			// bypass passes the parent straight through
			if (w[BIT_SEL_HI]) begin
				rate = p64;
			end else begin
				n = w[12:8] + 64'd1;
				k = w[5:4] + 64'd1;
				rate = (p64 * n * k) / 64'd2;
			end
		end
		SEL_DDR1: begin
			n = w[14:8] + 64'd1;
			m = w[1:0] + 64'd1;
			rate = (p64 * n) / m;
		end
		default: begin
			r.ok = 1'b0;
			rate = '0;
		end
		endcase
		r.rate = rate[RATE_W-1:0];
		return r;
	endfunction

	// Holds valid until the transaction is taken; returns at the accepting edge.
	task automatic send_query(logic [OPC_W-1:0] opc, logic [WORD_W-1:0] w,
			logic [WORD_W-1:0] par, logic typed, pll_result_t res);
		opcode <= opc;
		ctrl_word <= w;
		parent_rate <= par;
		row_typed <= typed;
		row_result <= res;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// Input acceptance and output check share one process so ordering is fixed.
	always @(posedge clk) begin
		pll_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				rate_q.push_back(row_typed ? row_result
					: calc_pll_rate(opcode, ctrl_word, parent_rate));
			if (out_valid && out_ready) begin
				if (rate_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result rate=%0d valid=%0b", $time,
						out_rate, select_valid);
				end else begin
					want = rate_q.pop_front();
					if (out_rate !== want.rate) begin
						err_cnt++;
						$display("%0t: out_rate expected %0d actual %0d", $time,
							want.rate, out_rate);
					end
					if (select_valid !== want.ok) begin
						err_cnt++;
						$display("%0t: select_valid expected %0b actual %0b", $time,
							want.ok, select_valid);
					end
				end
			end
		end
	end

	// Receiver: free-running, light stalls or heavy stalls; the mode is redrawn whenever stall_cnt wraps.
	always @(posedge clk) begin
		if (stall_cnt == 63) begin
			stall_cnt <= 0;
			stall_mode <= $urandom_range(0, 2);
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
		case (stall_mode)
		0: out_ready <= 1'b1;
		1: out_ready <= ($urandom_range(0, 3) != 0);
		default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int sent, burst, gap;
		logic [OPC_W-1:0] opc;
		logic [WORD_W-1:0] w, par;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_query(dir_rows[i].opc, dir_rows[i].word, dir_rows[i].parent,
				dir_rows[i].typed, '{rate: dir_rows[i].rate, ok: dir_rows[i].ok});
		in_valid <= 1'b0;
		// let the pipeline empty completely before the random part
		while (rate_q.size() != 0) @(posedge clk);

		sent = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 48);
			for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
				opc = ($urandom_range(0, 9) == 9)
					? OPC_W'($urandom_range(SEL_FIRST_BAD, SEL_LAST_BAD))
					: OPC_W'($urandom_range(SEL_CPU, SEL_DDR1));
				w = $urandom;
				case ($urandom_range(0, 3))
				0: par = $urandom;
				1: par = $urandom_range(0, 255);
				2: par = PAR_MAX - $urandom_range(0, 15);
				default: par = PAR_24M;
				endcase
				send_query(opc, w, par, 1'b0, '0);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		while (rate_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/prfcw_pkg.sv
rtl/core/prfcw_front.sv
rtl/core/prfcw_queue.sv
rtl/core/prfcw_back.sv
rtl/core/pll_rate_from_control_word_top.sv
rtl/core/prfcw_checker.sv
tb/pll_rate_from_control_word_top_tb.sv
